### sv/ostbc_pkg.sv
// ----------------------------------------------------------------------------
// Orthogonal STBC encoder package
// Shared types, code tables and the saturating value helpers.
// ----------------------------------------------------------------------------
package ostbc_pkg;

	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t re;
		sample_t im;
	} sym_t;

	typedef struct packed {
		sample_t sym_re;
		sample_t sym_im;
		logic    frame_end;
	} in_item_t;

	typedef struct packed {
		sample_t ant0_re;
		sample_t ant0_im;
		sample_t ant1_re;
		sample_t ant1_im;
		sample_t ant2_re;
		sample_t ant2_im;
		sample_t ant3_re;
		sample_t ant3_im;
		logic    last_row;
		logic    frame_error;
	} out_item_t;

	typedef enum logic [1:0] {
		CODE_G2,
		CODE_G3,
		CODE_G4,
		CODE_ERR
	} code_t;

	typedef struct packed {
		code_t        code;
		sym_t [3:0]   syms;
	} job_t;

	localparam logic [2:0] ANT_RESET = 3'd2;

	// Bit 2 requests negation, bits 1:0 select the stored symbol.
	localparam logic [2:0] OrthoTab [0:3][0:3] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd5, 3'd0, 3'd7, 3'd2},
		'{3'd6, 3'd3, 3'd0, 3'd5},
		'{3'd7, 3'd6, 3'd1, 3'd0}
	};

	localparam logic [2:0] G2Tab [0:1][0:1] = '{
		'{3'd0, 3'd1},
		'{3'd5, 3'd0}
	};

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	function automatic sample_t sat_neg(input sample_t v);
		sat_neg = (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
	endfunction

	function automatic sym_t ant_value(input sym_t s, input logic neg, input logic conj);
		sym_t r;
		r.re = neg ? sat_neg(s.re) : s.re;
		r.im = (neg ^ conj) ? sat_neg(s.im) : s.im;
		ant_value = r;
	endfunction

	function automatic code_t ant_code(input logic [2:0] ants);
		code_t c;
		case (ants)
			3'd0, 3'd1, 3'd2: c = CODE_G2;
			3'd3:             c = CODE_G3;
			default:          c = CODE_G4;
		endcase
		ant_code = c;
	endfunction

endpackage

### sv/ostbc_front.sv
// ----------------------------------------------------------------------------
// Orthogonal STBC encoder front end
// Collects symbols into a block and hands full or broken blocks to the queue.
// ----------------------------------------------------------------------------
module ostbc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  ostbc_pkg::in_item_t sym,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_antenna_count,
	input  logic              job_ready,
	output logic              job_valid,
	output ostbc_pkg::job_t   job
);
	import ostbc_pkg::*;

	logic [2:0] ant_q;
	logic [1:0] fill_q;
	sym_t       store_q [4];
	code_t      code;
	logic       take;
	logic       block_done;
	sym_t       cur;

	assign code       = ant_code(ant_q);
	assign sym_ready  = job_ready;
	assign take       = sym_valid && sym_ready;
	assign cur.re     = sym.sym_re;
	assign cur.im     = sym.sym_im;
	assign block_done = (code == CODE_G2) ? (fill_q == 2'd1) : (fill_q == 2'd3);
	assign job_valid  = take && (block_done || sym.frame_end);

	always_comb begin
		job.code = block_done ? code : CODE_ERR;
		for (int i = 0; i < 4; i++) begin
			job.syms[i] = (fill_q == i[1:0]) ? cur : store_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_q  <= ANT_RESET;
			fill_q <= '0;
		end else if (cfg_valid) begin
			ant_q  <= cfg_antenna_count;
			fill_q <= '0;
		end else if (take) begin
			fill_q <= (block_done || sym.frame_end) ? 2'd0 : fill_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_q[fill_q] <= cur;
		end
	end

endmodule

### sv/ostbc_queue.sv
// ----------------------------------------------------------------------------
// Orthogonal STBC encoder block queue
// Two-entry queue of blocks between the front end and the row generator.
// ----------------------------------------------------------------------------
module ostbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ostbc_pkg::job_t push_job,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output ostbc_pkg::job_t head
);
	import ostbc_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### sv/ostbc_back.sv
// ----------------------------------------------------------------------------
// Orthogonal STBC encoder row generator
// Walks the code rows of the head block and drives the output register.
// ----------------------------------------------------------------------------
module ostbc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  ostbc_pkg::job_t      job,
	output logic                 job_pop,
	output logic                 row_valid,
	input  logic                 row_ready,
	output ostbc_pkg::out_item_t row
);
	import ostbc_pkg::*;

	logic [2:0] idx_q;
	logic       row_valid_q;
	out_item_t  row_q;
	logic       load;
	logic       last;
	sym_t       vals [4];
	out_item_t  next_row;

	assign load = job_valid && (!row_valid_q || row_ready);

	always_comb begin
		case (job.code)
			CODE_G2:  last = (idx_q == 3'd1);
			CODE_ERR: last = 1'b1;
			default:  last = (idx_q == 3'd7);
		endcase
	end

	assign job_pop = load && last;

	always_comb begin
		logic [2:0] code3;
		logic       conj;
		logic       en;
		for (int a = 0; a < 4; a++) begin
			if (job.code == CODE_G2) begin
				code3 = G2Tab[idx_q[0]][a];
				conj  = idx_q[0];
			end else begin
				code3 = OrthoTab[idx_q[1:0]][a];
				conj  = idx_q[2];
			end
			case (job.code)
				CODE_G2: en = (a < 2);
				CODE_G3: en = (a < 3);
				CODE_G4: en = 1'b1;
				default: en = 1'b0;
			endcase
			vals[a] = en ? ant_value(job.syms[code3[1:0]], code3[2], conj) : '0;
		end
		next_row.ant0_re     = vals[0].re;
		next_row.ant0_im     = vals[0].im;
		next_row.ant1_re     = vals[1].re;
		next_row.ant1_im     = vals[1].im;
		next_row.ant2_re     = vals[2].re;
		next_row.ant2_im     = vals[2].im;
		next_row.ant3_re     = vals[3].re;
		next_row.ant3_im     = vals[3].im;
		next_row.last_row    = last && (job.code != CODE_ERR);
		next_row.frame_error = (job.code == CODE_ERR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			row_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
				row_valid_q <= 1'b1;
			end else if (row_ready) begin
				row_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= next_row;
		end
	end

	assign row_valid = row_valid_q;
	assign row       = row_q;

endmodule

### sv/orthogonal_stbc_encoder.sv
// ----------------------------------------------------------------------------
// Orthogonal space-time block encoder
// Alamouti G2 and the G3/G4 orthogonal codes, one code row per transfer.
// ----------------------------------------------------------------------------
// A symbol transfer is taken in any cycle in which the two-entry block queue
// has room. The row generator sends one code row per cycle while row_ready
// is held, so two-antenna operation sustains one symbol per cycle, while
// three and four antennas give eight rows per four symbols. A completed
// block is written into the queue, and its first row is then registered in
// the output register. A frame that ends inside a block yields a single
// row with frame_error set and all antenna values zero. Writing
// antenna_count drops any partly collected block.
module orthogonal_stbc_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_ready,
	input  ostbc_pkg::in_item_t  sym,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_antenna_count,
	output logic                 row_valid,
	input  logic                 row_ready,
	output ostbc_pkg::out_item_t row
);
	import ostbc_pkg::*;

	logic push;
	logic not_full;
	logic not_empty;
	logic pop;
	job_t push_job;
	job_t head;

	assign cfg_ready = 1'b1;

	ostbc_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.sym_valid         (sym_valid),
		.sym_ready         (sym_ready),
		.sym               (sym),
		.cfg_valid         (cfg_valid),
		.cfg_antenna_count (cfg_antenna_count),
		.job_ready         (not_full),
		.job_valid         (push),
		.job               (push_job)
	);

	ostbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	ostbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job       (head),
		.job_pop   (pop),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row       (row)
	);

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Orthogonal STBC encoder testbench
// Sends complex symbols under G2, G3 and G4 settings, including out-of-range
// antenna counts, saturating negation and frames that end inside a block.
// Every code row is checked field by field against an internal encoder model
// or a hand-written row, with random idling on both symbol and row channel.
// ----------------------------------------------------------------------------
module testbench;
	import ostbc_pkg::*;

	localparam int SYM_TOTAL = 230;
	localparam int CALM_TAIL = 40;
	localparam int SETTLE_CYCLES = 8;

	localparam sample_t S_MIN = 16'sh8000;
	localparam sample_t S_MAX = 16'sh7fff;

	localparam logic [1:0] PICK_SEL [0:3][0:3] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};
	localparam bit PICK_NEG [0:3][0:3] = '{
		'{1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b1, 1'b0, 1'b0}
	};
	localparam logic [2:0] FIRST_ANTS [0:2] = '{3'd5, 3'd6, 3'd3};

	typedef enum logic {
		STEP_SYM,
		STEP_CFG
	} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic [2:0] ants;
		in_item_t   item;
		int         n_typed;
	} plan_step_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       sym_valid;
	logic       sym_ready;
	in_item_t   sym;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_antenna_count;
	logic       row_valid;
	logic       row_ready;
	out_item_t  row;

	logic [2:0] ants_now;
	logic [2:0] fill_now;
	sym_t       held [0:3];
	out_item_t  new_rows [$];
	out_item_t  rows_due [$];
	out_item_t  typed_rows [$];
	plan_step_t plan [$];
	int         errors = 0;
	int         sent = 0;
	bit         calm = 1'b0;

	orthogonal_stbc_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym(sym),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_antenna_count(cfg_antenna_count),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row(row)
	);

	always #10 clk = ~clk;

	function automatic sample_t neg_sat(sample_t v);
		return (v == S_MIN) ? S_MAX : sample_t'(-v);
	endfunction

	function automatic sym_t antenna_value(sym_t s, bit neg, bit conj);
		sym_t v;
		v.re = neg ? neg_sat(s.re) : s.re;
		v.im = (neg != conj) ? neg_sat(s.im) : s.im;
		return v;
	endfunction

	function automatic code_t code_for(logic [2:0] ants);
		case (ants)
			3'd0, 3'd1, 3'd2: return CODE_G2;
			3'd3:             return CODE_G3;
			default:          return CODE_G4;
		endcase
	endfunction

	function automatic int block_len(code_t c);
		return (c == CODE_G2) ? 2 : 4;
	endfunction

	function automatic out_item_t make_row(sym_t a0, sym_t a1, sym_t a2, sym_t a3,
			logic last, logic err);
		return {a0, a1, a2, a3, last, err};
	endfunction

	function automatic void encode_symbol(in_item_t it);
		code_t code;
		int    blk;
		int    r;
		int    a;
		sym_t  v [0:3];
		code = code_for(ants_now);
		blk = block_len(code);
		new_rows.delete();
		held[fill_now[1:0]] = {it.sym_re, it.sym_im};
		fill_now = fill_now + 3'd1;
		if (fill_now < blk) begin
			if (it.frame_end) begin
				fill_now = '0;
				new_rows.push_back(make_row('0, '0, '0, '0, 1'b0, 1'b1));
			end
			return;
		end
		fill_now = '0;
		if (code == CODE_G2) begin
			new_rows.push_back(make_row(held[0], held[1], '0, '0, 1'b0, 1'b0));
			new_rows.push_back(make_row(antenna_value(held[1], 1'b1, 1'b1),
				antenna_value(held[0], 1'b0, 1'b1), '0, '0, 1'b1, 1'b0));
		end else begin
			for (r = 0; r < 8; r++) begin
				for (a = 0; a < 4; a++) begin
					v[a] = antenna_value(held[PICK_SEL[r[1:0]][a]], PICK_NEG[r[1:0]][a],
						r >= 4);
				end
				if (code == CODE_G3) begin
					v[3] = '0;
				end
				new_rows.push_back(make_row(v[0], v[1], v[2], v[3], r == 7, 1'b0));
			end
		end
	endfunction

	function automatic sample_t any_sample();
		case ($urandom_range(0, 7))
			0:       return S_MIN;
			1:       return S_MAX;
			2:       return '0;
			3:       return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_item(logic fe);
		return {any_sample(), any_sample(), fe};
	endfunction

	function automatic void plan_sym(sample_t re, sample_t im, logic fe, int n_typed = 0);
		plan_step_t s;
		s.kind = STEP_SYM;
		s.ants = '0;
		s.item = {re, im, fe};
		s.n_typed = n_typed;
		plan.push_back(s);
	endfunction

	function automatic void plan_cfg(logic [2:0] v);
		plan_step_t s;
		s.kind = STEP_CFG;
		s.ants = v;
		s.item = '0;
		s.n_typed = 0;
		plan.push_back(s);
	endfunction

	function automatic void match(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_symbol(in_item_t it, int n_typed);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sym_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		sym <= it;
		sym_valid <= 1'b1;
		@(posedge clk);
		while (!sym_ready) @(posedge clk);
		encode_symbol(it);
		if (n_typed == 0) begin
			foreach (new_rows[i]) rows_due.push_back(new_rows[i]);
		end else begin
			repeat (n_typed) rows_due.push_back(typed_rows.pop_front());
		end
		sent++;
		if (sent >= SYM_TOTAL - CALM_TAIL) begin
			calm = 1'b1;
		end
	endtask

	task automatic set_antennas(logic [2:0] v);
		sym_valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_antenna_count <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ants_now = v;
		fill_now = '0;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && row_valid && row_ready) begin
			if (rows_due.size() == 0) begin
				$error("row transfer with no expected row pending");
				errors++;
			end else begin
				want = rows_due.pop_front();
				match("ant0_re", want.ant0_re, row.ant0_re);
				match("ant0_im", want.ant0_im, row.ant0_im);
				match("ant1_re", want.ant1_re, row.ant1_re);
				match("ant1_im", want.ant1_im, row.ant1_im);
				match("ant2_re", want.ant2_re, row.ant2_re);
				match("ant2_im", want.ant2_im, row.ant2_im);
				match("ant3_re", want.ant3_re, row.ant3_re);
				match("ant3_im", want.ant3_im, row.ant3_im);
				match("last_row", want.last_row, row.last_row);
				match("frame_error", want.frame_error, row.frame_error);
			end
		end
	end

	initial begin
		row_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				row_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				row_ready <= 1'b1;
			end else begin
				row_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL orthogonal_stbc_encoder");
		$finish;
	end

	initial begin
		int         phase;
		int         seq;
		int         nseq;
		int         blk;
		int         len;
		int         choice;
		logic [2:0] ants;
		arst_n <= 1'b0;
		sym_valid <= 1'b0;
		sym <= '0;
		cfg_valid <= 1'b0;
		cfg_antenna_count <= '0;
		ants_now = ANT_RESET;
		fill_now = '0;
		foreach (held[i]) held[i] = '0;

		plan_sym(S_MIN, S_MIN, 1'b0);
		plan_sym(S_MAX, S_MAX, 1'b0, 2);
		typed_rows.push_back(make_row({S_MIN, S_MIN}, {S_MAX, S_MAX}, '0, '0, 1'b0, 1'b0));
		typed_rows.push_back(make_row({16'sh8001, S_MAX}, {S_MIN, S_MAX}, '0, '0,
			1'b1, 1'b0));
		plan_sym(16'sd1234, -16'sd5, 1'b1, 1);
		typed_rows.push_back(make_row('0, '0, '0, '0, 1'b0, 1'b1));
		plan_sym(S_MIN, S_MAX, 1'b0);
		plan_sym(-16'sd1, 16'sd0, 1'b1);
		plan_cfg(3'd3);
		plan_sym(S_MIN, 16'sd1, 1'b0);
		plan_sym(S_MAX, S_MIN, 1'b0);
		plan_sym(-16'sd2, S_MIN, 1'b0);
		plan_sym(16'sd0, S_MAX, 1'b1);
		plan_sym(16'sd77, -16'sd77, 1'b0);
		plan_cfg(3'd4);
		plan_sym(S_MIN, S_MIN, 1'b0);
		plan_sym(S_MAX, -16'sd1, 1'b0);
		plan_sym(16'sd300, S_MIN, 1'b0);
		plan_sym(S_MIN, -16'sd300, 1'b0);
		plan_sym(16'sd5, 16'sd6, 1'b0);
		plan_sym(16'sd7, 16'sd8, 1'b1, 1);
		typed_rows.push_back(make_row('0, '0, '0, '0, 1'b0, 1'b1));
		plan_cfg(3'd0);
		plan_sym(-16'sd7, S_MIN, 1'b0);
		plan_sym(S_MIN, 16'sd7, 1'b0);
		plan_cfg(3'd7);
		plan_sym(S_MAX, S_MAX, 1'b0);
		plan_sym(16'sd0, 16'sd0, 1'b0);
		plan_sym(S_MIN, S_MIN, 1'b0);
		plan_sym(16'sd1, -16'sd1, 1'b1);
		plan_cfg(3'd1);
		plan_sym(-16'sd3, 16'sd3, 1'b1, 1);
		typed_rows.push_back(make_row('0, '0, '0, '0, 1'b0, 1'b1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				set_antennas(plan[i].ants);
			end else begin
				send_symbol(plan[i].item, plan[i].n_typed);
			end
		end

		phase = 0;
		while (sent < SYM_TOTAL) begin
			ants = (phase < 3) ? FIRST_ANTS[phase] : 3'($urandom_range(0, 7));
			set_antennas(ants);
			phase++;
			nseq = $urandom_range(3, 8);
			for (seq = 0; seq < nseq && sent < SYM_TOTAL; seq++) begin
				blk = block_len(code_for(ants_now));
				choice = $urandom_range(0, 19);
				if (choice < 14) begin
					len = blk - fill_now;
					for (int k = 0; k < len; k++) begin
						send_symbol(rand_item((k == len - 1) ? 1'($urandom_range(0, 1)) : 1'b0), 0);
					end
				end else if (choice < 17) begin
					len = $urandom_range(1, blk - 1);
					for (int k = 0; k < len; k++) begin
						send_symbol(rand_item(k == len - 1), 0);
					end
				end else begin
					len = $urandom_range(1, 3);
					for (int k = 0; k < len; k++) begin
						send_symbol(rand_item(1'($urandom_range(0, 1))), 0);
					end
				end
			end
		end

		sym_valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS orthogonal_stbc_encoder");
		end else begin
			$display("FAIL orthogonal_stbc_encoder");
		end
		$finish;
	end

endmodule
